>>> rtl/core/loop_record_playback_buffer_defines.svh
// Assertion macros for the loop record/playback buffer.
`ifndef LOOP_RECORD_PLAYBACK_BUFFER_DEFINES_SVH
`define LOOP_RECORD_PLAYBACK_BUFFER_DEFINES_SVH

// same-cycle implication
`define LRPB_ASSERT_IMP(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error("lrpb: same-cycle check failed");

// next-cycle implication
`define LRPB_ASSERT_NXT(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error("lrpb: next-cycle check failed");

`endif

>>> rtl/core/lrpb_pkg.sv
// Shared types and codes of the loop record/playback buffer.
package lrpb_pkg;

	localparam int OP_BITS   = 3;
	localparam int OFS_BITS  = 13;
	localparam int GAIN_BITS = 16;

	localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'd32768;

	localparam logic [OP_BITS-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_BITS-1:0] OP_TICK   = 3'd1;
	localparam logic [OP_BITS-1:0] OP_REC    = 3'd2;
	localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd3;
	localparam logic [OP_BITS-1:0] OP_SMOOTH = 3'd4;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_PUSH,
		CMD_TICK,
		CMD_REC,
		CMD_CLEAR,
		CMD_SMOOTH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic signed [OFS_BITS-1:0]  offset;
		logic                        cosine;
	} cmd_t;

endpackage

>>> rtl/core/loop_record_playback_buffer.sv
// Each item passes the executor's address, modulo, read and output states; a bit-serial division
// runs when play index plus offset falls outside [-length, length) or the loop is empty; smooth
// first walks the loop memory. The executor takes a new command only when done with the last one;
// a two-item command queue and the result register let either side stall alone.
// Reset (arst_n low, async): length, play index, record mode, pass-through and gain clear to zero;
// the loop memory is not cleared and is defined only where written.
module loop_record_playback_buffer #(
	parameter int LOOP_DEPTH  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lrpb_pkg::GAIN_BITS-1:0]       cfg_wdata,
	input  logic                                 push,
	output logic                                 full,
	input  logic [lrpb_pkg::OP_BITS-1:0]         op,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic signed [lrpb_pkg::OFS_BITS-1:0] read_offset,
	input  logic                                 smooth_kind,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [SAMPLE_BITS-1:0]        play_value,
	output logic signed [SAMPLE_BITS-1:0]        mixed_value,
	output logic signed [SAMPLE_BITS-1:0]        offset_value,
	output logic                                 is_recording,
	output logic [$clog2(LOOP_DEPTH+1)-1:0]      loop_length,
	output logic                                 overflow
);

	import lrpb_pkg::*;

	`include "loop_record_playback_buffer_defines.svh"

	logic                   cmd_valid;
	logic                   cmd_pop;
	cmd_t                   cmd;
	logic signed [SAMPLE_BITS-1:0] cmd_sample;

	lrpb_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.sample      (sample),
		.read_offset (read_offset),
		.smooth_kind (smooth_kind),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd),
		.cmd_sample  (cmd_sample)
	);

	lrpb_back #(
		.LOOP_DEPTH  (LOOP_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.cmd_sample   (cmd_sample),
		.empty        (empty),
		.pop          (pop),
		.play_value   (play_value),
		.mixed_value  (mixed_value),
		.offset_value (offset_value),
		.is_recording (is_recording),
		.loop_length  (loop_length),
		.overflow     (overflow)
	);

	`LRPB_ASSERT_IMP(a_len_bound, clk, arst_n, !empty, loop_length <= LOOP_DEPTH)
	`LRPB_ASSERT_IMP(a_ovf_full, clk, arst_n, !empty && overflow, is_recording && (loop_length == LOOP_DEPTH))
	`LRPB_ASSERT_IMP(a_full_has_cmd, clk, arst_n, full, cmd_valid)
	`LRPB_ASSERT_NXT(a_accept_queued, clk, arst_n, push && !full, cmd_valid)

endmodule

>>> rtl/core/lrpb_ram.sv
// Generic RAM: one write port, two registered read ports.
module lrpb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/core/lrpb_mod.sv
// Signed remainder unit: signed sum mod divisor as a nonnegative remainder, one bit per cycle.
module lrpb_mod #(
	parameter int SUMW = 15,
	parameter int LW   = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [SUMW-1:0] sum,
	input  logic [LW-1:0]          divisor,
	output logic                   done,
	output logic [LW-1:0]          rem
);

	localparam int CW = $clog2(SUMW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [SUMW-1:0] mag_q;
	logic [LW-1:0]   r_q;
	logic [LW-1:0]   div_q;
	logic            neg_q;
	logic [LW-1:0]   rem_q;

	logic            sum_neg;
	logic [SUMW-1:0] div_ext;
	logic [SUMW-1:0] wrapped;
	logic            fast_pos;
	logic            fast_neg;
	logic [LW:0]     trial;
	logic [LW:0]     diff;
	logic [LW-1:0]   r_next;
	logic            last_step;

	assign sum_neg  = sum[SUMW-1];
	assign div_ext  = SUMW'(divisor);
	assign wrapped  = $unsigned(sum) + div_ext;
	// sum already lies in [0, divisor), or in [-divisor, 0) where adding the divisor wraps it
	assign fast_pos = !sum_neg && ($unsigned(sum) < div_ext);
	assign fast_neg = sum_neg && !wrapped[SUMW-1];

	assign trial     = {r_q, mag_q[SUMW-1]};
	assign diff      = trial - {1'b0, div_q};
	assign r_next    = diff[LW] ? trial[LW-1:0] : diff[LW-1:0];
	assign last_step = cnt_q == CW'(SUMW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (fast_pos || fast_neg) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			neg_q <= sum_neg;
			mag_q <= sum_neg ? $unsigned(-sum) : $unsigned(sum);
			r_q   <= '0;
			rem_q <= fast_neg ? wrapped[LW-1:0] : $unsigned(sum[LW-1:0]);
		end else if (busy_q) begin
			r_q   <= r_next;
			mag_q <= mag_q << 1;
			if (last_step) begin
				rem_q <= (neg_q && (r_next != '0)) ? div_q - r_next : r_next;
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> rtl/core/lrpb_front.sv
// Front end: accepts items, decodes the op, and queues commands for the executor.
module lrpb_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [lrpb_pkg::OP_BITS-1:0]         op,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic signed [lrpb_pkg::OFS_BITS-1:0] read_offset,
	input  logic                                 smooth_kind,
	output logic                                 cmd_valid,
	input  logic                                 cmd_pop,
	output lrpb_pkg::cmd_t                       cmd,
	output logic signed [SAMPLE_BITS-1:0]        cmd_sample
);

	import lrpb_pkg::*;

	localparam int QD = 2;

	cmd_t                    q_cmd_q [QD];
	logic signed [SAMPLE_BITS-1:0] q_smp_q [QD];
	logic                    wr_ptr_q;
	logic                    rd_ptr_q;
	logic [1:0]              cnt_q;

	cmd_t                    cls;
	logic                    accept;
	logic                    take;

	always_comb begin
		cls.offset = read_offset;
		cls.cosine = smooth_kind;
		case (op)
			OP_PUSH:   cls.kind = CMD_PUSH;
			OP_TICK:   cls.kind = CMD_TICK;
			OP_REC:    cls.kind = CMD_REC;
			OP_CLEAR:  cls.kind = CMD_CLEAR;
			OP_SMOOTH: cls.kind = CMD_SMOOTH;
			default:   cls.kind = CMD_NOP;
		endcase
	end

	assign full      = cnt_q == 2'(QD);
	assign cmd_valid = cnt_q != 2'd0;
	assign accept    = push && !full;
	assign take      = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (accept && !take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (take && !accept) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_cmd_q[wr_ptr_q] <= cls;
			q_smp_q[wr_ptr_q] <= sample;
		end
	end

	assign cmd        = q_cmd_q[rd_ptr_q];
	assign cmd_sample = q_smp_q[rd_ptr_q];

endmodule

>>> rtl/core/lrpb_back.sv
// Executor: loop state, loop memory, smoothing walk, reads, mix and result register.
module lrpb_back #(
	parameter int LOOP_DEPTH  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lrpb_pkg::GAIN_BITS-1:0]        cfg_wdata,
	input  logic                                  cmd_valid,
	output logic                                  cmd_pop,
	input  lrpb_pkg::cmd_t                        cmd,
	input  logic signed [SAMPLE_BITS-1:0]         cmd_sample,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [SAMPLE_BITS-1:0]         play_value,
	output logic signed [SAMPLE_BITS-1:0]         mixed_value,
	output logic signed [SAMPLE_BITS-1:0]         offset_value,
	output logic                                  is_recording,
	output logic [$clog2(LOOP_DEPTH+1)-1:0]       loop_length,
	output logic                                  overflow
);

	import lrpb_pkg::*;

	localparam int SW   = SAMPLE_BITS;
	localparam int IW   = $clog2(LOOP_DEPTH);
	localparam int LW   = $clog2(LOOP_DEPTH + 1);
	localparam int SUMW = ((IW > OFS_BITS) ? IW : OFS_BITS) + 2;
	localparam int PW   = SW + GAIN_BITS + 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ADDR   = 4'd1;
	localparam logic [3:0] S_MOD    = 4'd2;
	localparam logic [3:0] S_RDB    = 4'd3;
	localparam logic [3:0] S_OUT    = 4'd4;
	localparam logic [3:0] S_SM0    = 4'd5;
	localparam logic [3:0] S_SM1    = 4'd6;
	localparam logic [3:0] S_SM2    = 4'd7;
	localparam logic [3:0] S_SMLAST = 4'd8;

	// floor((a*wa + b*wb) / 65536); cosine weights fold to 16384*(a+b) + (a-b) over 32768
	function automatic logic signed [SW-1:0] blend(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b, input logic cosine);
		logic signed [SW:0]    s;
		logic signed [SW:0]    d;
		logic signed [SW+15:0] v;
		s = {a[SW-1], a} + {b[SW-1], b};
		d = {a[SW-1], a} - {b[SW-1], b};
		v = (SW+16)'(s) <<< 14;
		if (cosine) begin
			v = v + (SW+16)'(d);
		end
		return v[SW+14:15];
	endfunction

	logic [3:0]            state_q;
	logic [LW-1:0]         len_q;
	logic [IW-1:0]         idx_q;
	logic                  rec_q;
	logic signed [SW-1:0]  pass_q;
	logic [GAIN_BITS-1:0]  gain_q;
	logic                  out_valid_q;

	cmd_t                  cur_q;
	logic                  ovf_q;
	logic [IW-1:0]         sm_i_q;
	logic signed [SW-1:0]  sm_cur_q;
	logic signed [SW-1:0]  sm_first_q;
	logic signed [SW-1:0]  play_q;
	logic signed [SW-1:0]  offv_q;
	logic signed [PW-1:0]  prod_q;

	logic signed [SW-1:0]  play_out_q;
	logic signed [SW-1:0]  mix_out_q;
	logic signed [SW-1:0]  offs_out_q;
	logic                  rec_out_q;
	logic [LW-1:0]         len_out_q;
	logic                  ovf_out_q;

	logic                  full_loop;
	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	logic [SW-1:0]         ram_wdata;
	logic [IW-1:0]         ram_ra;
	logic [IW-1:0]         ram_rb;
	logic [SW-1:0]         ram_rd_a;
	logic [SW-1:0]         ram_rd_b;
	logic signed [SW-1:0]  rd_a_s;
	logic signed [SW-1:0]  rd_b_s;
	logic [IW-1:0]         last_addr;
	logic signed [SW-1:0]  blend_w;

	logic                  mod_start;
	logic signed [SUMW-1:0] mod_sum;
	logic                  mod_done;
	logic [LW-1:0]         mod_rem;

	logic signed [SW-1:0]  play_sel;
	logic signed [SW:0]    diff;
	logic signed [GAIN_BITS:0] g_s;
	logic signed [PW-1:0]  prod;
	logic signed [PW-1:0]  mix_full;
	logic                  out_free;
	logic                  sm_last_next;

	assign full_loop = len_q == LW'(LOOP_DEPTH);
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign rd_a_s    = $signed(ram_rd_a);
	assign rd_b_s    = $signed(ram_rd_b);
	assign last_addr = IW'(len_q - LW'(1));
	assign blend_w   = blend(sm_cur_q, (state_q == S_SMLAST) ? sm_first_q : rd_a_s,
		cur_q.cosine);
	assign sm_last_next = (LW'(sm_i_q) + LW'(2)) == len_q;

	assign ram_we = (cmd_pop && (cmd.kind == CMD_PUSH) && rec_q && !full_loop)
		|| (state_q == S_SM2) || (state_q == S_SMLAST);

	always_comb begin
		case (state_q)
			S_SM2:    ram_waddr = sm_i_q;
			S_SMLAST: ram_waddr = last_addr;
			default:  ram_waddr = len_q[IW-1:0];
		endcase
		ram_wdata = ((state_q == S_SM2) || (state_q == S_SMLAST)) ? blend_w : cmd_sample;
		case (state_q)
			S_SM0:   ram_ra = '0;
			S_SM1:   ram_ra = IW'(1);
			S_SM2:   ram_ra = sm_i_q + IW'(2);
			default: ram_ra = idx_q;
		endcase
	end

	assign ram_rb = mod_rem[IW-1:0];

	lrpb_ram #(
		.WIDTH (SW),
		.DEPTH (LOOP_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_ra),
		.rdata_a (ram_rd_a),
		.raddr_b (ram_rb),
		.rdata_b (ram_rd_b)
	);

	assign mod_start = state_q == S_ADDR;
	assign mod_sum   = {{(SUMW-IW){1'b0}}, idx_q}
		+ {{(SUMW-OFS_BITS){cur_q.offset[OFS_BITS-1]}}, cur_q.offset};

	lrpb_mod #(
		.SUMW (SUMW),
		.LW   (LW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.sum     (mod_sum),
		.divisor (len_q),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// mixed = pass + floor((play - pass) * g / 32768)
	assign play_sel = ((len_q != '0) && !rec_q) ? rd_a_s : pass_q;
	assign diff     = {play_sel[SW-1], play_sel} - {pass_q[SW-1], pass_q};
	assign g_s      = $signed({1'b0, gain_q});
	assign prod     = diff * g_s;
	assign mix_full = PW'(pass_q) + (prod_q >>> 15);
	assign out_free = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			rec_q       <= 1'b0;
			pass_q      <= '0;
			gain_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				gain_q <= (cfg_wdata > GAIN_UNITY) ? GAIN_UNITY : cfg_wdata;
			end
			// a new result may land in the same cycle the old one leaves
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							CMD_PUSH: begin
								pass_q <= cmd_sample;
								if (rec_q && !full_loop) begin
									len_q <= len_q + LW'(1);
								end
							end
							CMD_TICK: begin
								if (len_q != '0) begin
									idx_q <= ((LW'(idx_q) + LW'(1)) == len_q) ? '0
										: idx_q + IW'(1);
								end
							end
							CMD_REC: rec_q <= !rec_q;
							CMD_CLEAR: begin
								len_q <= '0;
								idx_q <= '0;
							end
							default: ;
						endcase
						// a single-entry loop smooths to itself
						if ((cmd.kind == CMD_SMOOTH) && (len_q > LW'(1))) begin
							state_q <= S_SM0;
						end else begin
							state_q <= S_ADDR;
						end
					end
				end
				S_SM0:    state_q <= S_SM1;
				S_SM1:    state_q <= S_SM2;
				S_SM2: begin
					if (sm_last_next) begin
						state_q <= S_SMLAST;
					end
				end
				S_SMLAST: state_q <= S_ADDR;
				S_ADDR:   state_q <= S_MOD;
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_RDB;
					end
				end
				S_RDB:    state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
			ovf_q <= (cmd.kind == CMD_PUSH) && rec_q && full_loop;
		end
		if (state_q == S_SM0) begin
			sm_i_q <= '0;
		end
		if (state_q == S_SM1) begin
			sm_cur_q <= rd_a_s;
		end
		if (state_q == S_SM2) begin
			if (sm_i_q == '0) begin
				sm_first_q <= blend_w;
			end
			sm_cur_q <= rd_a_s;
			sm_i_q   <= sm_i_q + IW'(1);
		end
		if (state_q == S_RDB) begin
			play_q <= play_sel;
			offv_q <= (len_q == '0) ? pass_q : rd_b_s;
			prod_q <= prod;
		end
		if ((state_q == S_OUT) && out_free) begin
			play_out_q <= play_q;
			mix_out_q  <= mix_full[SW-1:0];
			offs_out_q <= offv_q;
			rec_out_q  <= rec_q;
			len_out_q  <= len_q;
			ovf_out_q  <= ovf_q;
		end
	end

	assign empty        = !out_valid_q;
	assign play_value   = play_out_q;
	assign mixed_value  = mix_out_q;
	assign offset_value = offs_out_q;
	assign is_recording = rec_out_q;
	assign loop_length  = len_out_q;
	assign overflow     = ovf_out_q;

endmodule
